// ===== hw/rtl/iale_pkg.sv =====
// Shared types, opcodes, status codes and sizes for the array list engine.
// No dependencies.
package iale_pkg;
  localparam int Depth = 16;
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  typedef enum logic [3:0] {
    OP_APPEND = 4'd0, OP_INSERT = 4'd1, OP_REMOVE = 4'd2, OP_GET = 4'd3,
    OP_SET = 4'd4, OP_LSEARCH = 4'd5, OP_BSEARCH = 4'd6, OP_SINSERT = 4'd7,
    OP_REVERSE = 4'd8, OP_ROTATE = 4'd9, OP_MAXMIN = 4'd10, OP_SUM = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_RANGE = 3'd1, ST_FULL = 3'd2, ST_NOTFOUND = 3'd3,
    ST_UNSORTED = 3'd4, ST_EMPTY = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_WORK, S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [3:0]         index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [35:0] data;
    logic signed [31:0] data_min;
    logic [4:0]         fill_count;
  } out_item_t;
endpackage

// ===== hw/rtl/indexed_array_list_engine.sv =====
// Array list engine top level: request sequencer over a 16-word register
// store. Depends on iale_pkg.
//
// channel  | ports                       | role
// in       | in_valid/in_ready/in_data   | request transaction
// out      | out_valid/out_ready/out_data| one result per request
//
// One request at a time; in_ready is low from accept until the result is loaded.
// Simple ops and errors finish without a walk. Walks visit one entry per cycle
// (shared compare/add unit): shifts, linear search, rotate, maxmin and sum.
// Binary search and sorted insert first scan count-1 pairs for order, one pair
// per cycle, before their own work.
// Reset clears count and control; store contents stay undefined until written.
// A stalled result holds in the output register; the next result waits in S_DONE.
module indexed_array_list_engine import iale_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic [31:0] mem_r [Depth];
  logic [CW-1:0] cnt_r, cnt_nxt;
  state_t st_r, st_nxt;
  in_item_t req_r, req_nxt;
  logic [CW-1:0] i_r, i_nxt;       // walk pointer
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic sorted_r, sorted_nxt, scan_r, scan_nxt;
  logic signed [35:0] acc_r, acc_nxt;
  logic signed [31:0] mn_r, mn_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [31:0] first_r, first_nxt;
  out_item_t out_r, out_nxt;
  logic ov_r, ov_nxt;
  logic we;
  logic [AW-1:0] wa;
  logic [31:0] wd;
  logic we2;
  logic [AW-1:0] wa2;
  logic [31:0] wd2;
  logic signed [31:0] ea, eb;
  logic [CW-1:0] mid;
  logic [CW:0] s;
  logic signed [36:0] sum;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
    req_r <= req_nxt; i_r <= i_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    sorted_r <= sorted_nxt; scan_r <= scan_nxt; acc_r <= acc_nxt; mn_r <= mn_nxt;
    stat_r <= stat_nxt; first_r <= first_nxt; out_r <= out_nxt;
    if (we) mem_r[wa] <= wd;
    if (we2) mem_r[wa2] <= wd2;
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ov_nxt = ov_r; req_nxt = req_r;
    i_nxt = i_r; lo_nxt = lo_r; hi_nxt = hi_r; sorted_nxt = sorted_r;
    scan_nxt = scan_r; acc_nxt = acc_r; mn_nxt = mn_r; stat_nxt = stat_r;
    first_nxt = first_r; out_nxt = out_r;
    we = 1'b0; wa = '0; wd = '0; we2 = 1'b0; wa2 = '0; wd2 = '0;
    ea = '0; eb = '0; s = '0; mid = '0; sum = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          i_nxt = CW'(1);
          sorted_nxt = 1'b1;
          scan_nxt = (in_data.op == OP_BSEARCH) || (in_data.op == OP_SINSERT);
          stat_nxt = ST_OK;
          acc_nxt = '0;
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // optional sortedness scan, one adjacent pair per cycle
        if (scan_r && i_r < cnt_r) begin
          ea = mem_r[AW'(i_r - CW'(1))];
          eb = mem_r[AW'(i_r)];
          if (ea > eb) sorted_nxt = 1'b0;
          i_nxt = i_r + CW'(1);
        end else begin
          st_nxt = S_WORK;
          lo_nxt = '0;
          hi_nxt = cnt_r;  // exclusive upper bound for binary search
          case (req_r.op)
            OP_APPEND: begin
              if (cnt_r >= CW'(Depth)) begin stat_nxt = ST_FULL; st_nxt = S_DONE; end
              else begin
                we = 1'b1; wa = AW'(cnt_r); wd = req_r.value;
                cnt_nxt = cnt_r + CW'(1); st_nxt = S_DONE;
              end
            end
            OP_INSERT: begin
              if (CW'(req_r.index) > cnt_r) begin stat_nxt = ST_RANGE; st_nxt = S_DONE; end
              else if (cnt_r >= CW'(Depth)) begin stat_nxt = ST_FULL; st_nxt = S_DONE; end
              else i_nxt = cnt_r;
            end
            OP_REMOVE, OP_GET, OP_SET: begin
              if (CW'(req_r.index) >= cnt_r) begin stat_nxt = ST_RANGE; st_nxt = S_DONE; end
              else begin
                acc_nxt = 36'(signed'(mem_r[AW'(req_r.index)]));
                i_nxt = CW'(req_r.index);
                if (req_r.op == OP_SET) begin
                  we = 1'b1; wa = AW'(req_r.index); wd = req_r.value;
                  acc_nxt = '0; st_nxt = S_DONE;
                end else if (req_r.op == OP_GET) st_nxt = S_DONE;
              end
            end
            OP_LSEARCH: begin stat_nxt = ST_NOTFOUND; i_nxt = '0; end
            OP_BSEARCH: begin
              if (!sorted_r) begin stat_nxt = ST_UNSORTED; st_nxt = S_DONE; end
              else stat_nxt = ST_NOTFOUND;
            end
            OP_SINSERT: begin
              if (!sorted_r) begin stat_nxt = ST_UNSORTED; st_nxt = S_DONE; end
              else if (cnt_r >= CW'(Depth)) begin stat_nxt = ST_FULL; st_nxt = S_DONE; end
              else i_nxt = cnt_r;
            end
            OP_REVERSE: begin
              i_nxt = '0;
              hi_nxt = (cnt_r == '0) ? '0 : cnt_r - CW'(1);
            end
            OP_ROTATE: begin
              if (cnt_r == '0) begin stat_nxt = ST_EMPTY; st_nxt = S_DONE; end
              else begin first_nxt = mem_r[0]; i_nxt = CW'(1); end
            end
            OP_MAXMIN: begin
              if (cnt_r == '0) begin stat_nxt = ST_EMPTY; st_nxt = S_DONE; end
              else begin
                acc_nxt = 36'(signed'(mem_r[0]));
                mn_nxt = mem_r[0]; i_nxt = CW'(1);
              end
            end
            OP_SUM: i_nxt = '0;
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_WORK: begin
        case (req_r.op)
          OP_INSERT: begin
            if (i_r > CW'(req_r.index)) begin
              we = 1'b1; wa = AW'(i_r); wd = mem_r[AW'(i_r - CW'(1))];
              i_nxt = i_r - CW'(1);
            end else begin
              we = 1'b1; wa = AW'(i_r); wd = req_r.value;
              cnt_nxt = cnt_r + CW'(1); st_nxt = S_DONE;
            end
          end
          OP_SINSERT: begin
            ea = (i_r == '0) ? '0 : mem_r[AW'(i_r - CW'(1))];
            if (i_r != '0 && ea > req_r.value) begin
              we = 1'b1; wa = AW'(i_r); wd = ea; i_nxt = i_r - CW'(1);
            end else begin
              we = 1'b1; wa = AW'(i_r); wd = req_r.value;
              cnt_nxt = cnt_r + CW'(1); st_nxt = S_DONE;
            end
          end
          OP_REMOVE: begin
            if (i_r + CW'(1) < cnt_r) begin
              we = 1'b1; wa = AW'(i_r); wd = mem_r[AW'(i_r + CW'(1))];
              i_nxt = i_r + CW'(1);
            end else begin
              cnt_nxt = cnt_r - CW'(1); st_nxt = S_DONE;
            end
          end
          OP_LSEARCH: begin
            if (i_r < cnt_r && mem_r[AW'(i_r)] == req_r.value) begin
              stat_nxt = ST_OK; acc_nxt = 36'(i_r); st_nxt = S_DONE;
            end else if (i_r + CW'(1) >= cnt_r) st_nxt = S_DONE;
            else i_nxt = i_r + CW'(1);
          end
          OP_BSEARCH: begin
            if (lo_r < hi_r) begin
              s = {1'b0, lo_r} + {1'b0, hi_r} - (CW + 1)'(1);
              mid = CW'(s >> 1);
              ea = mem_r[AW'(mid)];
              if (ea == req_r.value) begin
                stat_nxt = ST_OK; acc_nxt = 36'(mid); st_nxt = S_DONE;
              end else if (ea < req_r.value) lo_nxt = mid + CW'(1);
              else hi_nxt = mid;
            end else st_nxt = S_DONE;
          end
          OP_REVERSE: begin
            if (i_r < hi_r) begin
              we = 1'b1; wa = AW'(i_r); wd = mem_r[AW'(hi_r)];
              we2 = 1'b1; wa2 = AW'(hi_r); wd2 = mem_r[AW'(i_r)];
              i_nxt = i_r + CW'(1); hi_nxt = hi_r - CW'(1);
            end else st_nxt = S_DONE;
          end
          OP_ROTATE: begin
            if (i_r < cnt_r) begin
              we = 1'b1; wa = AW'(i_r - CW'(1)); wd = mem_r[AW'(i_r)];
              i_nxt = i_r + CW'(1);
            end else begin
              we = 1'b1; wa = AW'(cnt_r - CW'(1)); wd = first_r; st_nxt = S_DONE;
            end
          end
          OP_MAXMIN: begin
            if (i_r < cnt_r) begin
              ea = mem_r[AW'(i_r)];
              if (36'(ea) > acc_r) acc_nxt = 36'(ea);
              if (ea < mn_r) mn_nxt = ea;
              i_nxt = i_r + CW'(1);
            end else st_nxt = S_DONE;
          end
          OP_SUM: begin
            if (i_r < cnt_r) begin
              ea = mem_r[AW'(i_r)];
              sum = 37'(acc_r) + 37'(ea);
              if (sum > 37'sd34359738367) acc_nxt = 36'sh7FFFFFFFF;
              else if (sum < -37'sd34359738368) acc_nxt = 36'sh800000000;
              else acc_nxt = sum[35:0];
              i_nxt = i_r + CW'(1);
            end else st_nxt = S_DONE;
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          out_nxt.status = stat_r;
          out_nxt.data = (stat_r == ST_OK) ? acc_r : '0;
          out_nxt.data_min = (stat_r == ST_OK && req_r.op == OP_MAXMIN) ? mn_r : '0;
          out_nxt.fill_count = 5'(cnt_r);
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/iale_checker.sv =====
// Port-level checks for the array list engine, bound to the top level.
// Depends on iale_pkg.
module iale_checker import iale_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second request while busy");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fill_count <= 5'(Depth))
    else $error("fill count beyond depth");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.data == '0 && out_data.data_min == '0)
    else $error("error result carries data");
endmodule

bind indexed_array_list_engine iale_checker u_iale_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for indexed_array_list_engine: directed and random requests,
// a scoreboard class predicting each result. Depends on iale_pkg and the top level RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iale_pkg::*;

  class list_scoreboard;
    logic signed [31:0] words[Depth];
    int unsigned        fill;
    out_item_t          pending[$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function void clear();
      fill = 0;
      pending.delete();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function bit ordered();
      for (int i = 1; i < fill; i++)
        if (words[i-1] > words[i]) return 0;
      return 1;
    endfunction

    function void note_request(in_item_t req);
      status_t            st;
      logic signed [35:0] acc;
      logic signed [31:0] lo_val, first;
      logic signed [31:0] tmp;
      int                 lo, hi, mid, p;
      out_item_t          r;
      st = ST_OK;
      acc = '0;
      lo_val = '0;
      case (req.op)
        OP_APPEND: begin
          if (fill >= Depth) st = ST_FULL;
          else begin
            words[fill] = req.value;
            fill++;
          end
        end
        OP_INSERT: begin
          if (req.index > fill) st = ST_RANGE;
          else if (fill >= Depth) st = ST_FULL;
          else begin
            for (int i = fill; i > req.index; i--) words[i] = words[i-1];
            words[req.index] = req.value;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (req.index >= fill) st = ST_RANGE;
          else begin
            acc = 36'(words[req.index]);
            for (int i = req.index; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        OP_GET: begin
          if (req.index >= fill) st = ST_RANGE;
          else acc = 36'(words[req.index]);
        end
        OP_SET: begin
          if (req.index >= fill) st = ST_RANGE;
          else words[req.index] = req.value;
        end
        OP_LSEARCH: begin
          st = ST_NOTFOUND;
          for (int i = 0; i < fill; i++)
            if (words[i] == req.value) begin
              st = ST_OK;
              acc = 36'(i);
              break;
            end
        end
        OP_BSEARCH: begin
          if (!ordered()) st = ST_UNSORTED;
          else begin
            st = ST_NOTFOUND;
            lo = 0;
            hi = int'(fill) - 1;
            while (lo <= hi) begin
              mid = (lo + hi) / 2;
              if (words[mid] == req.value) begin
                st = ST_OK;
                acc = 36'(mid);
                break;
              end
              if (words[mid] < req.value) lo = mid + 1;
              else hi = mid - 1;
            end
          end
        end
        OP_SINSERT: begin
          if (!ordered()) st = ST_UNSORTED;
          else if (fill >= Depth) st = ST_FULL;
          else begin
            p = fill;
            while (p > 0 && words[p-1] > req.value) begin
              words[p] = words[p-1];
              p--;
            end
            words[p] = req.value;
            fill++;
          end
        end
        OP_REVERSE: begin
          for (int i = 0; i < int'(fill) / 2; i++) begin
            tmp = words[i];
            words[i] = words[fill-1-i];
            words[fill-1-i] = tmp;
          end
        end
        OP_ROTATE: begin
          if (fill == 0) st = ST_EMPTY;
          else begin
            first = words[0];
            for (int i = 1; i < fill; i++) words[i-1] = words[i];
            words[fill-1] = first;
          end
        end
        OP_MAXMIN: begin
          if (fill == 0) st = ST_EMPTY;
          else begin
            acc = 36'(words[0]);
            lo_val = words[0];
            for (int i = 1; i < fill; i++) begin
              if (36'(words[i]) > acc) acc = 36'(words[i]);
              if (words[i] < lo_val) lo_val = words[i];
            end
          end
        end
        OP_SUM: begin
          // at depth 16 the sum cannot leave the 36-bit range
          for (int i = 0; i < fill; i++) acc = acc + 36'(words[i]);
        end
        default: ;
      endcase
      r.status = st;
      r.data = acc;
      r.data_min = lo_val;
      r.fill_count = 5'(fill);
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.data !== want.data ||
          got.data_min !== want.data_min || got.fill_count !== want.fill_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch #%0d: status exp %0d got %0d, data exp %0d got %0d, ",
                    "min exp %0d got %0d, fill exp %0d got %0d"},
                   results_seen, want.status, got.status, want.data, got.data,
                   want.data_min, got.data_min, want.fill_count, got.fill_count);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  list_scoreboard sb;
  int unsigned    idle_cycles;
  int unsigned    requests_sent;
  bit             stall_free;

  localparam int unsigned WatchdogLimit = 20000;

  indexed_array_list_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // in_valid is dropped only when a gap follows, so it is assigned once per edge
  task automatic send_request(logic [3:0] op, logic [3:0] idx, logic signed [31:0] val);
    int unsigned g;
    in_item_t    req;
    g = stall_free ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.op = op;
    req.index = idx;
    req.value = val;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 7) - 3;
      default: return $urandom();
    endcase
  endfunction

  // result side: random backpressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= (stall_free || gap_len() == 0) ? 1'b1 : 1'b0;
    end
  end

  // watchdog: cycles without any transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("** indexed_array_list_engine: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0]  op;
    int unsigned f;
    sb = new();
    sb.clear();
    requests_sent = 0;
    stall_free = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list cases, fill to full, edges of all ops but set and linear search
    send_request(OP_REVERSE, 4'd0, 32'sd0);
    send_request(OP_ROTATE, 4'd0, 32'sd0);
    send_request(OP_MAXMIN, 4'd0, 32'sd0);
    send_request(OP_SUM, 4'd0, 32'sd0);
    send_request(OP_BSEARCH, 4'd0, 32'sd5);
    send_request(OP_GET, 4'd0, 32'sd0);
    send_request(OP_INSERT, 4'd1, 32'sd1);
    send_request(OP_INSERT, 4'd0, 32'sh80000000);
    for (int i = 0; i < 15; i++) send_request(OP_APPEND, 4'(i), 32'sh7fffffff - (14 - i));
    send_request(OP_APPEND, 4'hf, 32'sd0);
    send_request(OP_INSERT, 4'hf, 32'sd0);
    send_request(OP_SINSERT, 4'd0, 32'sd0);
    send_request(OP_BSEARCH, 4'd0, 32'sh7fffffff);
    send_request(OP_SUM, 4'd0, 32'sd0);
    send_request(OP_REMOVE, 4'hf, 32'sd0);
    send_request(4'hc, 4'hf, 32'shffffffff);
    send_request(4'hf, 4'ha, 32'sh55555555);

    // random phase; stretches without idling now and then
    for (int n = 0; n < 500; n++) begin
      if (n % 100 == 50) stall_free = 1;
      if (n % 100 == 75) stall_free = 0;
      f = sb.fill;
      case ($urandom_range(0, 19))
        0, 1, 2: op = OP_APPEND;
        3, 4: op = OP_INSERT;
        5, 6: op = OP_REMOVE;
        7: op = OP_GET;
        8: op = OP_SET;
        9: op = OP_LSEARCH;
        10, 11: op = OP_BSEARCH;
        12, 13: op = OP_SINSERT;
        14: op = OP_REVERSE;
        15: op = OP_ROTATE;
        16: op = OP_MAXMIN;
        17: op = OP_SUM;
        18: op = 4'($urandom_range(12, 15));
        default: op = 4'($urandom_range(0, 15));
      endcase
      if (f > 0 && $urandom_range(0, 2) != 0)
        send_request(op, 4'($urandom_range(0, f - 1)),
                     ($urandom_range(0, 1) ? sb.words[$urandom_range(0, f - 1)] : rand_word()));
      else
        send_request(op, 4'($urandom()), rand_word());
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d requests over all twelve operations, empty and full lists,",
             requests_sent);
    $display("with random gaps and backpressure; %0d results checked", sb.results_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** indexed_array_list_engine: PASSED **");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("** indexed_array_list_engine: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/iale_pkg.sv
hw/rtl/indexed_array_list_engine.sv
hw/rtl/iale_checker.sv
tb/tb_top.sv
